// File: rtl/core/pll_config_word_builder_macros.svh
// Assertion macros for the PLL control word builder.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef PLL_CONFIG_WORD_BUILDER_MACROS_SVH
`define PLL_CONFIG_WORD_BUILDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCWB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define PCWB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/pcwb_pkg.sv
// Types, constants and helper functions for the PLL control word builder.
// No dependencies; imported by every module of the block.
package pcwb_pkg;

  localparam int unsigned DIV_WIDTH           = 32;
  localparam int unsigned DIV_STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES          = DIV_WIDTH / DIV_STEPS_PER_STAGE;

  localparam logic [31:0] PLL_MIN_HZ     = 32'd400000000;
  localparam logic [31:0] PLL_MAX_HZ     = 32'd1030000000;
  localparam logic [31:0] BAND1_FROM_HZ  = 32'd460000000;
  localparam logic [31:0] BAND2_FROM_HZ  = 32'd530000000;
  localparam logic [31:0] GAP_LO_FROM_HZ = 32'd615000000;
  localparam logic [31:0] GAP_LO_TO_HZ   = 32'd650000000;
  localparam logic [31:0] BAND4_FROM_HZ  = 32'd790000000;
  localparam logic [31:0] GAP_HI_FROM_HZ = 32'd875000000;
  localparam logic [31:0] GAP_HI_TO_HZ   = 32'd920000000;

  localparam logic [15:0] PUMP_MIN_UA    = 16'd237;
  localparam logic [15:0] PUMP_OFFSET_UA = 16'd212;
  localparam logic [15:0] PUMP_STEP_UA   = 16'd15;
  localparam int unsigned PUMP_CODE_MAX  = 7;

  localparam int unsigned RATIO_BITS = 7;   // ratio must be below 128

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_MULT   = 3'd1;
  localparam logic [2:0] ST_ZERO_RATIO = 3'd2;
  localparam logic [2:0] ST_BIG_RATIO  = 3'd3;
  localparam logic [2:0] ST_OUT_RANGE  = 3'd4;
  localparam logic [2:0] ST_LOW_GAP    = 3'd5;
  localparam logic [2:0] ST_HIGH_GAP   = 3'd6;

  localparam logic [2:0] BAND_MAX = 3'd5;

  typedef struct packed {
    logic [31:0] pll_hz;
    logic [31:0] ref_hz;
    logic [15:0] pump_ua;
  } req_t;

  typedef struct packed {
    logic [31:0] control_word;
    logic [2:0]  status;
  } rsp_t;

  // word travelling down the divider
  typedef struct packed {
    logic [DIV_WIDTH-1:0] rem;
    logic [DIV_WIDTH-1:0] quo;      // dividend shifts out, quotient shifts in
    logic [DIV_WIDTH-1:0] divisor;
    logic                 ref_zero;
    logic [2:0]           pre_status;
    logic [2:0]           band;
    logic [2:0]           pump_code;
  } div_t;

  function automatic logic [2*DIV_WIDTH-1:0] div_step(
    input logic [DIV_WIDTH-1:0] rem,
    input logic [DIV_WIDTH-1:0] quo,
    input logic [DIV_WIDTH-1:0] divisor
  );
    logic [DIV_WIDTH:0]   trial;
    logic [DIV_WIDTH:0]   diff;
    logic [DIV_WIDTH-1:0] rem_n;
    logic [DIV_WIDTH-1:0] quo_n;
    trial = {rem, quo[DIV_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_n = diff[DIV_WIDTH-1:0];
      quo_n = {quo[DIV_WIDTH-2:0], 1'b1};
    end else begin
      rem_n = trial[DIV_WIDTH-1:0];
      quo_n = {quo[DIV_WIDTH-2:0], 1'b0};
    end
    return {rem_n, quo_n};
  endfunction

  // (pump - 212) / 15, zero below 237, saturated at 7: count thresholds passed
  function automatic logic [2:0] pump_code(input logic [15:0] pump);
    logic [2:0]  code;
    logic [16:0] thr;
    code = (pump >= PUMP_MIN_UA) ? 3'd1 : 3'd0;
    for (int k = 2; k <= PUMP_CODE_MAX; k++) begin
      thr = {1'b0, PUMP_OFFSET_UA} + 17'(PUMP_STEP_UA * 16'(k));
      if ({1'b0, pump} >= thr) begin
        code = code + 3'd1;
      end
    end
    return code;
  endfunction

  function automatic logic [2:0] vco_band(input logic [31:0] pll);
    logic [2:0] band;
    if (pll <= BAND1_FROM_HZ) begin
      band = 3'd0;
    end else if (pll < BAND2_FROM_HZ) begin
      band = 3'd1;
    end else if (pll < GAP_LO_FROM_HZ) begin
      band = 3'd2;
    end else if (pll < BAND4_FROM_HZ) begin
      band = 3'd3;
    end else if (pll < GAP_HI_FROM_HZ) begin
      band = 3'd4;
    end else begin
      band = BAND_MAX;
    end
    return band;
  endfunction

  // range and band-gap checks, in priority order
  function automatic logic [2:0] freq_status(input logic [31:0] pll);
    logic [2:0] st;
    if (pll < PLL_MIN_HZ || pll > PLL_MAX_HZ) begin
      st = ST_OUT_RANGE;
    end else if (pll >= GAP_LO_FROM_HZ && pll < GAP_LO_TO_HZ) begin
      st = ST_LOW_GAP;
    end else if (pll >= GAP_HI_FROM_HZ && pll < GAP_HI_TO_HZ) begin
      st = ST_HIGH_GAP;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

// File: rtl/core/pcwb_div_stage.sv
// One divider stage: two restoring-division steps and the stage register.
// Depends on pcwb_pkg.
module pcwb_div_stage
  import pcwb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic prev_valid,
  input  div_t prev,
  output logic valid,
  output div_t data
);

  div_t data_next;

  always_comb begin
    data_next = prev;
    for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
      {data_next.rem, data_next.quo} = div_step(data_next.rem, data_next.quo,
                                                data_next.divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/core/pll_config_word_builder.sv
// PLL control word builder, top level.
// Depends on pcwb_pkg, pcwb_div_stage and pll_config_word_builder_macros.svh.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries pll_hz, ref_hz, pump_ua.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns control_word and status,
//   one word per request, in order.
//   A request is taken into the entry register, then passes 16 divider
//   stages of two quotient bits each, then the check/pack register that
//   drives rsp.
//   Throughput: one word per cycle while rsp_stall is low, set by the 32-step
//   restoring divider laid out as 16 stages.
//   Each stage has its own valid bit and moves on when the next stage is
//   empty or moving, so bubbles close up when rsp_stall is high and the
//   block keeps taking requests until every stage is full.
//   req_stall rises only when the entry stage is full and cannot move.
//   A held result is not altered while rsp_stall is high.
//   Reset (rst, synchronous, active high) clears all valid bits; words in
//   flight are dropped.
module pll_config_word_builder
  import pcwb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

`include "pll_config_word_builder_macros.svh"

  localparam int unsigned LAST = DIV_STAGES + 1;

  div_t            st [DIV_STAGES+1];
  logic [LAST:0]   v;
  logic [LAST+1:0] adv;
  logic            entry_valid;
  div_t            entry;
  rsp_t            rsp_next;

  // advance chain, from the output back
  always_comb begin
    adv[LAST+1] = !rsp_stall;
    for (int i = LAST; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign req_stall = !adv[0];

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (adv[0]) begin
      entry_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      entry.rem        <= '0;
      entry.quo        <= req.pll_hz;
      entry.divisor    <= req.ref_hz;
      entry.ref_zero   <= (req.ref_hz == '0);
      entry.pre_status <= freq_status(req.pll_hz);
      entry.band       <= vco_band(req.pll_hz);
      entry.pump_code  <= pump_code(req.pump_ua);
    end
  end

  assign v[0]  = entry_valid;
  assign st[0] = entry;

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    pcwb_div_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .load       (adv[g]),
      .prev_valid (v[g-1]),
      .prev       (st[g-1]),
      .valid      (v[g]),
      .data       (st[g])
    );
  end

  // checks in priority order, then pack
  always_comb begin
    rsp_next.control_word = '0;
    if (st[DIV_STAGES].ref_zero || st[DIV_STAGES].rem != '0) begin
      rsp_next.status = ST_NOT_MULT;
    end else if (st[DIV_STAGES].quo == '0) begin
      rsp_next.status = ST_ZERO_RATIO;
    end else if (st[DIV_STAGES].quo[DIV_WIDTH-1:RATIO_BITS] != '0) begin
      rsp_next.status = ST_BIG_RATIO;
    end else if (st[DIV_STAGES].pre_status != ST_OK) begin
      rsp_next.status = st[DIV_STAGES].pre_status;
    end else begin
      rsp_next.status                  = ST_OK;
      rsp_next.control_word[26:24]     = st[DIV_STAGES].band;
      rsp_next.control_word[21:19]     = st[DIV_STAGES].pump_code;
      rsp_next.control_word[14]        = 1'b1;
      rsp_next.control_word[8]         = 1'b1;
      rsp_next.control_word[7:1]       = st[DIV_STAGES].quo[RATIO_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv[LAST]) begin
      rsp_valid <= v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      rsp <= rsp_next;
    end
  end

  assign v[LAST] = rsp_valid;

  `PCWB_ASSERT_ALWAYS(a_stall_only_when_full, rst || !req_stall || v[0], "stall with empty entry stage")
  `PCWB_ASSERT(a_err_word_zero, !(rsp_valid && rsp.status != ST_OK) || rsp.control_word == '0, "nonzero word on error")
  `PCWB_ASSERT(a_ok_word_shape, !(rsp_valid && rsp.status == ST_OK) || (rsp.control_word[14] && rsp.control_word[8] && rsp.control_word[7:1] != '0 && rsp.control_word[26:24] <= BAND_MAX), "malformed control word")
  `PCWB_ASSERT(a_status_range, !rsp_valid || rsp.status != 3'd7, "status code out of range")

endmodule

// File: tb/pcwb_word_checker.sv
// Checker for the PLL control word builder: watches both channels, predicts
// each response word from the request and compares in order.
// Depends on pcwb_pkg for the payload types and the status codes.
module pcwb_word_checker
  import pcwb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   passed
);

  rsp_t expected_words[$];
  int   err_count = 0;
  int   chk_count = 0;
  int   ok_count  = 0;

  function automatic rsp_t build_control_word(input req_t r);
    rsp_t        w;
    logic [31:0] ratio;
    logic [2:0]  band;
    int unsigned code;
    w.control_word = '0;
    w.status       = ST_OK;
    band           = 3'd0;
    ratio          = '0;
    code           = 0;
    if (r.ref_hz == '0 || (r.pll_hz % r.ref_hz) != '0) begin
      w.status = ST_NOT_MULT;
    end else begin
      ratio = r.pll_hz / r.ref_hz;
      if (ratio == '0) begin
        w.status = ST_ZERO_RATIO;
      end else if (ratio >= (32'd1 << RATIO_BITS)) begin
        w.status = ST_BIG_RATIO;
      end else if (r.pll_hz < PLL_MIN_HZ || r.pll_hz > PLL_MAX_HZ) begin
        w.status = ST_OUT_RANGE;
      end else if (r.pll_hz >= GAP_LO_FROM_HZ && r.pll_hz < GAP_LO_TO_HZ) begin
        w.status = ST_LOW_GAP;
      end else if (r.pll_hz >= GAP_HI_FROM_HZ && r.pll_hz < GAP_HI_TO_HZ) begin
        w.status = ST_HIGH_GAP;
      end else begin
        if (r.pll_hz <= BAND1_FROM_HZ) begin
          band = 3'd0;
        end else if (r.pll_hz < BAND2_FROM_HZ) begin
          band = 3'd1;
        end else if (r.pll_hz < GAP_LO_FROM_HZ) begin
          band = 3'd2;
        end else if (r.pll_hz < BAND4_FROM_HZ) begin
          band = 3'd3;
        end else if (r.pll_hz < GAP_HI_FROM_HZ) begin
          band = 3'd4;
        end else begin
          band = 3'd5;
        end
        if (r.pump_ua >= PUMP_MIN_UA) begin
          code = (32'(r.pump_ua) - 32'(PUMP_OFFSET_UA)) / 32'(PUMP_STEP_UA);
        end
        if (code > PUMP_CODE_MAX) begin
          code = PUMP_CODE_MAX;
        end
        // band 26:24, pump 21:19, fixed 14 and 8, ratio 7:1
        w.control_word = {5'd0, band, 2'd0, code[2:0], 4'd0, 1'b1, 5'd0, 1'b1,
                          ratio[6:0], 1'b0};
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_words.push_back(build_control_word(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected word: word %h status %0d", rsp.control_word, rsp.status);
          end
        end else begin
          want = expected_words.pop_front();
          chk_count++;
          if (rsp.control_word !== want.control_word || rsp.status !== want.status) begin
            err_count++;
            if (err_count <= 10) begin
              $display("word mismatch: expected word %h status %0d, got word %h status %0d",
                       want.control_word, want.status, rsp.control_word, rsp.status);
            end
          end else if (want.status == ST_OK) begin
            ok_count++;
          end
        end
      end
    end
    errors  <= err_count;
    pending <= expected_words.size();
    checked <= chk_count;
    passed  <= ok_count;
  end

endmodule

// File: tb/tb_pll_config_word_builder.sv
// Testbench top for the PLL control word builder: drives requests with
// random gaps and response stalls, and gives the verdict.
// Depends on pcwb_pkg, pll_config_word_builder and pcwb_word_checker.
module tb_pll_config_word_builder;
  import pcwb_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic calm      = 1'b0;

  int          errors;
  int          pending;
  int          checked;
  int          passed;
  int unsigned words_sent = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  pll_config_word_builder u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  pcwb_word_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .passed    (passed)
  );

  task automatic send_req(input logic [31:0] pll, input logic [31:0] ref_clk,
                          input logic [15:0] pump);
    while (!calm && $urandom_range(0, 99) < 13) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{pll_hz: pll, ref_hz: ref_clk, pump_ua: pump};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  // ratio of one: pll equal to the reference, so any frequency, a boundary included, can be hit exactly
  task automatic send_unity(input logic [31:0] f, input logic [15:0] pump);
    send_req(f, f, pump);
  endtask

  function automatic logic [31:0] freq_edge(input int unsigned k);
    case (k)
      0:       return PLL_MIN_HZ;
      1:       return PLL_MAX_HZ;
      2:       return BAND1_FROM_HZ;
      3:       return BAND2_FROM_HZ;
      4:       return GAP_LO_FROM_HZ;
      5:       return GAP_LO_TO_HZ;
      6:       return BAND4_FROM_HZ;
      7:       return GAP_HI_FROM_HZ;
      default: return GAP_HI_TO_HZ;
    endcase
  endfunction

  function automatic logic [15:0] rand_pump();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(200, 330));
      5, 6, 7:       return 16'($urandom);
      default: begin
        case ($urandom_range(0, 7))
          0:       return 16'd0;
          1:       return 16'd236;
          2:       return 16'd237;
          3:       return 16'd241;
          4:       return 16'd242;
          5:       return 16'd316;
          6:       return 16'd317;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned kind;
    int unsigned ratio;
    logic [31:0] target;
    logic [31:0] ref_clk;
    logic [31:0] pll;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // error priority and field extremes
    send_req(32'd0, 32'd0, 16'd0);
    send_req(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_req(32'hFFFFFFFF, 32'd0, 16'd0);
    send_req(32'd0, 32'hFFFFFFFF, 16'd237);
    send_req(32'd1000, 32'd3, 16'd236);
    send_req(32'd640000000, 32'd5000000, 16'd241);
    send_req(32'd1016000000, 32'd8000000, 16'd242);
    // band and gap boundaries
    send_unity(PLL_MIN_HZ, 16'd316);
    send_unity(PLL_MIN_HZ - 32'd1, 16'd317);
    send_unity(BAND1_FROM_HZ, 16'd100);
    send_unity(BAND1_FROM_HZ + 32'd1, 16'd250);
    send_unity(BAND2_FROM_HZ - 32'd1, 16'd260);
    send_unity(BAND2_FROM_HZ, 16'd275);
    send_unity(GAP_LO_FROM_HZ - 32'd1, 16'd290);
    send_unity(GAP_LO_FROM_HZ, 16'd300);
    send_unity(GAP_LO_TO_HZ - 32'd1, 16'd305);
    send_unity(GAP_LO_TO_HZ, 16'd212);
    send_unity(BAND4_FROM_HZ - 32'd1, 16'd32768);
    send_unity(BAND4_FROM_HZ, 16'd257);
    send_unity(GAP_HI_FROM_HZ - 32'd1, 16'd270);
    send_unity(GAP_HI_FROM_HZ, 16'd280);
    send_unity(GAP_HI_TO_HZ - 32'd1, 16'd285);
    send_unity(GAP_HI_TO_HZ, 16'd330);
    send_unity(PLL_MAX_HZ, 16'hFFFF);
    send_unity(PLL_MAX_HZ + 32'd1, 16'd1);

    for (int i = 0; i < 700; i++) begin
      calm <= (i >= 300 && i < 420);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // exact multiple aimed at the legal frequency span
        ratio = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 127);
        if ($urandom_range(0, 2) == 0) begin
          target = freq_edge($urandom_range(0, 8)) + 32'($urandom_range(0, 6)) - 32'd3;
        end else begin
          target = $urandom_range(380000000, 1050000000);
        end
        ref_clk = target / ratio;
        pll     = ref_clk * ratio;
      end else if (kind < 70) begin
        ratio   = $urandom_range(0, 255);
        ref_clk = $urandom_range(1, 32'hFFFFFFFF / ((ratio == 0) ? 1 : ratio));
        pll     = ref_clk * ratio;
      end else if (kind < 78) begin
        if ($urandom_range(0, 1) == 0) begin
          pll     = 32'd0;
          ref_clk = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        end else begin
          pll     = $urandom;
          ref_clk = 32'd0;
        end
      end else begin
        pll     = $urandom;
        ref_clk = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 1000);
      end
      send_req(pll, ref_clk, rand_pump());
    end
    req_valid <= 1'b0;
    calm      <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("requests sent: %0d (boundaries, error priority, random multiples)", words_sent);
    $display("responses checked: %0d, accepted with a control word: %0d", checked, passed);
    if (errors == 0 && pending == 0) begin
      $display("tb_pll_config_word_builder: clean");
    end else begin
      $display("tb_pll_config_word_builder: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb_pll_config_word_builder: errors");
    $finish;
  end

endmodule
